[hdl/sha256_sha224_hash_engine_unit_defines.svh]
// assertion macros for the sha-256 / sha-224 engine
`ifndef SHA256_SHA224_HASH_ENGINE_UNIT_DEFINES_SVH
`define SHA256_SHA224_HASH_ENGINE_UNIT_DEFINES_SVH

// property that must hold on every clock edge outside reset
`define SHA_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// two conditions that must never be high together outside reset
`define SHA_ASSERT_EXCL(label, clk, rstn, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !((a) && (b))) else $error(msg);

`endif

[hdl/sha_pkg.sv]
// shared constants and functions for the sha-256 / sha-224 engine
package sha_pkg;

    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned BYTE_IDX_W  = 6;
    localparam int unsigned ROUND_W     = 6;
    localparam int unsigned TOTAL_W     = 61;
    localparam logic [7:0]  PAD_BYTE    = 8'h80;
    localparam logic [5:0]  LENGTH_POS  = 6'd56;

    typedef logic [31:0] word_t;

    // round start request passed from control to the round unit
    typedef struct packed {
        logic start;
        logic init_chain;
    } rnd_ctrl_t;

    function automatic word_t iv_word(input logic mode_224, input logic [2:0] idx);
        word_t r;
        r = 32'h0;
        if (mode_224) begin
            unique case (idx)
                3'd0: r = 32'hC1059ED8;
                3'd1: r = 32'h367CD507;
                3'd2: r = 32'h3070DD17;
                3'd3: r = 32'hF70E5939;
                3'd4: r = 32'hFFC00B31;
                3'd5: r = 32'h68581511;
                3'd6: r = 32'h64F98FA7;
                3'd7: r = 32'hBEFA4FA4;
                default: r = 32'h0;
            endcase
        end else begin
            unique case (idx)
                3'd0: r = 32'h6A09E667;
                3'd1: r = 32'hBB67AE85;
                3'd2: r = 32'h3C6EF372;
                3'd3: r = 32'hA54FF53A;
                3'd4: r = 32'h510E527F;
                3'd5: r = 32'h9B05688C;
                3'd6: r = 32'h1F83D9AB;
                3'd7: r = 32'h5BE0CD19;
                default: r = 32'h0;
            endcase
        end
        return r;
    endfunction

    function automatic word_t round_k(input logic [ROUND_W-1:0] i);
        word_t k [64];
        k = '{
            32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
            32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
            32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
            32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
            32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
            32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
            32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
            32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
            32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
            32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
            32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
            32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
            32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
            32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
            32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
            32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2};
        return k[i];
    endfunction

endpackage

[hdl/sha_round.sv]
// shared compression round unit: one round per cycle with a rolling schedule
module sha_round import sha_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  rnd_ctrl_t ctrl,
    input  logic      mode_224,
    // block words loaded serially: word i of the block on load_en
    input  logic      load_en,
    input  word_t     load_word,
    output logic      busy,
    output logic      done,
    input  logic [2:0] rd_idx,
    output word_t     rd_word
);

    word_t chain_reg [8];
    word_t v_reg [8];
    word_t w_reg [16];
    logic [ROUND_W-1:0] rnd_reg;
    logic busy_reg, done_reg;

    word_t s0, s1, w_new, wi, t1, t2, bs0, bs1, ch, maj;

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // round arithmetic
    always_comb begin
        wi  = w_reg[0];
        s0  = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1  = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = s1 + w_reg[9] + s0 + w_reg[0];
        bs1 = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        ch  = v_reg[6] ^ (v_reg[4] & (v_reg[5] ^ v_reg[6]));
        t1  = v_reg[7] + bs1 + ch + round_k(rnd_reg) + wi;
        bs0 = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        maj = (v_reg[0] & v_reg[1]) | (v_reg[2] & (v_reg[0] | v_reg[1]));
        t2  = bs0 + maj;
    end

    // schedule window, working variables and chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rnd_reg  <= '0;
            for (int i = 0; i < 8; i++) chain_reg[i] <= iv_word(1'b0, 3'(i));
        end else begin
            done_reg <= 1'b0;
            if (ctrl.init_chain) begin
                for (int i = 0; i < 8; i++) chain_reg[i] <= iv_word(mode_224, 3'(i));
            end
            if (load_en) begin
                for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
                w_reg[15] <= load_word;
            end
            if (ctrl.start) begin
                busy_reg <= 1'b1;
                rnd_reg  <= '0;
                for (int i = 0; i < 8; i++) v_reg[i] <= chain_reg[i];
            end else if (busy_reg) begin
                for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
                w_reg[15] <= w_new;
                v_reg[7] <= v_reg[6]; v_reg[6] <= v_reg[5]; v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= v_reg[2]; v_reg[2] <= v_reg[1]; v_reg[1] <= v_reg[0];
                v_reg[0] <= t1 + t2;
                rnd_reg  <= rnd_reg + 1'b1;
                if (rnd_reg == 6'd63) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end else if (done_reg) begin
                for (int i = 0; i < 8; i++) chain_reg[i] <= chain_reg[i] + v_reg[i];
            end
        end
    end

    assign busy    = busy_reg | done_reg;
    assign done    = done_reg;
    assign rd_word = chain_reg[rd_idx];

endmodule

[hdl/sha256_sha224_hash_engine_unit.sv]
// top level of the sha-256 / sha-224 engine: byte gathering, padding, sequencing
//
// channel   dir  payload
// s_        in   tdata[7:0] data_byte, tuser byte_valid, tlast end_of_message
// m_        out  tdata[31:0] digest_word, tuser[2:0] word_index, tlast last_word
// cfg_      in   cfg_wdata mode_224
//
// an accepted byte is stored; a byte that completes a block starts the load
// (64 registered store reads plus the round start), the rounds and one
// chain update, run by the shared round unit at one round per cycle.
// a final item runs one or two such blocks, then 7 or 8 output words.
// reset is synchronous, active low. s_tready is low from block fill to the
// last digest word; a stalled m_ side holds the current word.
`include "sha256_sha224_hash_engine_unit_defines.svh"
module sha256_sha224_hash_engine_unit import sha_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tuser,   // byte_valid
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // digest_word
    output logic [2:0]  m_tuser,   // word_index
    output logic        m_tlast,   // last_word
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_wdata  // mode_224
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_LOAD, ST_RUN, ST_PAD, ST_OUT
    } state_t;

    state_t state_reg;
    logic   mode_reg;
    logic   mode_next;
    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] total_inc;
    logic   final_reg;       // padding pending for this message
    logic   len_blk_reg;     // current block carries the length
    logic   pad_blk_flag_reg; // current block carries the 0x80 byte
    logic [3:0] ld_reg;
    logic [2:0] out_reg;
    logic   m_valid_reg;

    logic [BYTE_IDX_W-1:0] wr_addr, rd_addr;
    logic [7:0] wr_data, rd_data;
    logic       wr_en;
    logic [1:0] bsel_reg;
    logic [BYTE_IDX_W-1:0] pad_pos_reg;
    word_t asm_reg;

    logic [BYTE_IDX_W-1:0] rd_cnt;
    logic [7:0] blk_byte;
    logic [5:0] rd_pos_reg;
    logic rd_valid_reg;
    logic [4:0] words_loaded_reg;

    rnd_ctrl_t rctl;
    logic busy, done, load_en;
    word_t rd_word;
    logic s_hs, cfg_hs, m_hs;
    logic [63:0] bits;
    logic [BYTE_IDX_W-1:0] pos;

    assign s_hs   = s_tvalid & s_tready;
    assign m_hs   = m_tvalid & m_tready;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign cfg_hs = cfg_valid & cfg_ready;
    assign s_tready = (state_reg == ST_IDLE) & ~cfg_valid;
    assign pos  = total_reg[BYTE_IDX_W-1:0];
    assign bits = {total_reg, 3'b000};
    assign total_inc = total_reg + TOTAL_W'(s_tuser);
    // a mode write reloads the chain for the new mode
    assign mode_next = cfg_hs ? cfg_wdata : mode_reg;

    // byte store: written on accepted bytes with byte_valid set, read while loading words
    sha_ram #(.WIDTH(8), .DEPTH(BLOCK_BYTES)) u_store (
        .clk(aclk), .we(wr_en), .waddr(wr_addr), .wdata(wr_data),
        .raddr(rd_addr), .rdata(rd_data)
    );

    sha_round u_round (
        .aclk(aclk), .aresetn(aresetn), .ctrl(rctl), .mode_224(mode_next),
        .load_en(load_en), .load_word({asm_reg[23:0], blk_byte}), .busy(busy),
        .done(done), .rd_idx(out_reg), .rd_word(rd_word)
    );

    // byte feed into the ram
    always_comb begin
        wr_en   = s_hs && s_tuser;
        wr_addr = pos;
        wr_data = s_tdata;
    end

    // block byte reader: padding and length are overlaid on the stored bytes
    assign rd_cnt  = {ld_reg, bsel_reg};
    assign rd_addr = rd_cnt;

    always_comb begin
        blk_byte = rd_data;
        if (final_reg) begin
            if (len_blk_reg && rd_pos_reg >= LENGTH_POS)
                blk_byte = bits[{~rd_pos_reg[2:0], 3'b111} -: 8];
            else if (pad_blk_flag_reg && rd_pos_reg == pad_pos_reg)
                blk_byte = PAD_BYTE;
            else if (pad_blk_flag_reg && rd_pos_reg > pad_pos_reg)
                blk_byte = 8'h00;
            else if (!pad_blk_flag_reg && len_blk_reg)
                blk_byte = 8'h00;
        end
    end

    // a word is complete when its fourth byte arrives
    assign load_en = rd_valid_reg && (rd_pos_reg[1:0] == 2'd3);

    always_comb begin
        rctl.start = 1'b0;
        rctl.init_chain = cfg_hs;
        if (state_reg == ST_LOAD && words_loaded_reg == 5'd16) rctl.start = 1'b1;
        if (state_reg == ST_OUT && m_hs && m_tlast) rctl.init_chain = 1'b1;
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mode_reg  <= 1'b0;
            total_reg <= '0;
            final_reg <= 1'b0;
            len_blk_reg <= 1'b0;
            pad_blk_flag_reg <= 1'b0;
            ld_reg <= '0; bsel_reg <= '0;
            rd_valid_reg <= 1'b0;
            words_loaded_reg <= '0;
            out_reg <= '0;
            m_valid_reg <= 1'b0;
            pad_pos_reg <= '0;
        end else begin
            rd_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (cfg_hs) begin
                        mode_reg <= cfg_wdata;
                        total_reg <= '0;
                    end else if (s_hs) begin
                        total_reg <= total_inc;
                        final_reg <= s_tlast;
                        pad_pos_reg <= total_inc[BYTE_IDX_W-1:0];
                        if (s_tuser && total_inc[BYTE_IDX_W-1:0] == '0) begin
                            state_reg <= ST_LOAD;
                            len_blk_reg <= 1'b0;
                            pad_blk_flag_reg <= 1'b0;
                            ld_reg <= '0; bsel_reg <= '0; words_loaded_reg <= '0;
                        end else if (s_tlast) begin
                            state_reg <= ST_LOAD;
                            len_blk_reg <= (total_inc[BYTE_IDX_W-1:0] < LENGTH_POS);
                            pad_blk_flag_reg <= 1'b1;
                            ld_reg <= '0; bsel_reg <= '0; words_loaded_reg <= '0;
                        end
                    end
                end
                ST_LOAD: begin
                    if (words_loaded_reg != 5'd16) begin
                        // 64 reads; stop once the address has wrapped
                        if (!(rd_cnt == '0 && rd_valid_reg)) begin
                            rd_valid_reg <= 1'b1;
                            rd_pos_reg <= rd_cnt;
                            {ld_reg, bsel_reg} <= rd_cnt + 1'b1;
                        end
                        if (rd_valid_reg) begin
                            asm_reg <= {asm_reg[23:0], blk_byte};
                        end
                        if (load_en) words_loaded_reg <= words_loaded_reg + 1'b1;
                    end else begin
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (done) state_reg <= ST_PAD;
                end
                ST_PAD: begin
                    // the chain update lands on entry here; decide the next block
                    if (final_reg && !len_blk_reg) begin
                        // second block: 0x80 goes here only if the first had none
                        len_blk_reg <= 1'b1;
                        pad_blk_flag_reg <= !pad_blk_flag_reg;
                        state_reg <= ST_LOAD;
                        ld_reg <= '0; bsel_reg <= '0; words_loaded_reg <= '0;
                    end else if (final_reg) begin
                        state_reg <= ST_OUT;
                        out_reg <= '0;
                        m_valid_reg <= 1'b1;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_OUT: begin
                    if (m_hs) begin
                        if (m_tlast) begin
                            m_valid_reg <= 1'b0;
                            state_reg <= ST_IDLE;
                            total_reg <= '0;
                            final_reg <= 1'b0;
                        end else begin
                            out_reg <= out_reg + 1'b1;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = rd_word;
    assign m_tuser  = out_reg;
    assign m_tlast  = mode_reg ? (out_reg == 3'd6) : (out_reg == 3'd7);

    `SHA_ASSERT_EXCL(a_no_in_while_out, aclk, aresetn, m_tvalid, s_tready, "input taken during digest")
    `SHA_ASSERT(a_out_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tuser)), "output word dropped")
    `SHA_ASSERT(a_busy_blocks, aclk, aresetn, busy |-> !s_tready, "input taken while rounds run")

endmodule

[hdl/sha_ram.sv]
// generic single-port-write ram with registered read
module sha_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
